@@ rtl/cpi_pkg.sv @@
// Shared constants, widths and the CORDIC arctangent table for the polar interpolator.
package cpi_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DATA_WIDTH_DEF    = 32;
    localparam int CORDIC_STAGES_DEF = 20;

    // Binary angle width: angles stay well inside +/- 2^20.
    localparam int ZW       = 22;
    localparam int WEIGHT_W = 17;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic signed [ZW-1:0] ANGLE_PI      = 22'sd524288;
    localparam logic signed [ZW-1:0] ANGLE_HALF_PI = 22'sd262144;

    // Inverse of the squared CORDIC gain in Q0.20.
    localparam int INV_GAIN_W = 19;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN_SQ_Q20 = 19'd386669;

    // Arctangent of 2^-i, with 2^19 standing for pi.
    function automatic logic signed [ZW-1:0] ang_of(input int step);
        logic signed [ZW-1:0] a;
        case (step)
            0:       a = 22'sd131072;
            1:       a = 22'sd77376;
            2:       a = 22'sd40884;
            3:       a = 22'sd20753;
            4:       a = 22'sd10417;
            5:       a = 22'sd5213;
            6:       a = 22'sd2607;
            7:       a = 22'sd1304;
            8:       a = 22'sd652;
            9:       a = 22'sd326;
            10:      a = 22'sd163;
            11:      a = 22'sd81;
            12:      a = 22'sd41;
            13:      a = 22'sd20;
            14:      a = 22'sd10;
            15:      a = 22'sd5;
            16:      a = 22'sd3;
            17:      a = 22'sd1;
            18:      a = 22'sd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/cpi_vec_cell.sv @@
// One vectoring CORDIC cell: a single micro-rotation toward the x axis.
module cpi_vec_cell #(
    parameter int XW   = 35,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [cpi_pkg::ZW-1:0] i_z,
    input  logic                          i_zero,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [cpi_pkg::ZW-1:0] o_z,
    output logic                          o_zero
);
    import cpi_pkg::*;

    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;

    // Rotate so that y moves toward zero, accumulating the angle.
    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + ang_of(STEP);
        end else begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - ang_of(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_x    <= n_x;
            o_y    <= n_y;
            o_z    <= n_z;
            o_zero <= i_zero;
        end
    end
endmodule

@@ rtl/cpi_rot_cell.sv @@
// One rotation CORDIC cell: a single micro-rotation driving the residual angle to zero.
module cpi_rot_cell #(
    parameter int XW   = 35,
    parameter int STEP = 0
) (
    input  logic                          i_clk,
    input  logic                          i_ce,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [cpi_pkg::ZW-1:0] i_z,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [cpi_pkg::ZW-1:0] o_z
);
    import cpi_pkg::*;

    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;

    // Rotate in the direction of the remaining angle.
    always_comb begin
        if (!i_z[ZW-1]) begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
            n_z = i_z - ang_of(STEP);
        end else begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
            n_z = i_z + ang_of(STEP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            o_x <= n_x;
            o_y <= n_y;
            o_z <= n_z;
        end
    end
endmodule

@@ rtl/cpi_blend.sv @@
// Four-stage blend of magnitudes and angles, gain correction and quadrant fold.
module cpi_blend #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_ce,
    input  logic [cpi_pkg::WEIGHT_W-1:0]        i_weight,
    input  logic [DATA_WIDTH:0]                 i_mag_a,
    input  logic [DATA_WIDTH:0]                 i_mag_b,
    input  logic signed [cpi_pkg::ZW-1:0]       i_ang_a,
    input  logic signed [cpi_pkg::ZW-1:0]       i_ang_b,
    output logic signed [DATA_WIDTH+2:0]        o_x,
    output logic signed [cpi_pkg::ZW-1:0]       o_z
);
    import cpi_pkg::*;

    localparam int XW  = DATA_WIDTH + 3;
    localparam int MAW = DATA_WIDTH + 1;
    localparam int MPW = MAW + WEIGHT_W;
    localparam int MW  = DATA_WIDTH + 2;
    localparam int GPW = MW + INV_GAIN_W;
    localparam int APW = ZW + WEIGHT_W + 1;

    logic [WEIGHT_W-1:0] w_b, w_a;

    logic [MPW-1:0]        r_mpa, r_mpb;
    logic signed [APW-1:0] r_apa, r_apb;
    logic [MW-1:0]         r_m;
    logic signed [ZW-1:0]  r_p1, r_p2;
    logic [GPW-1:0]        r_g;

    logic [MPW:0]          n_ra, n_rb;
    logic signed [APW:0]   n_asum;
    logic signed [APW:0]   n_ash;
    logic [GPW-1:0]        n_gr;
    logic [MW-1:0]         n_mg;
    logic signed [XW-1:0]  n_x;
    logic signed [ZW-1:0]  n_z;

    // Weight above one is taken as one.
    assign w_b = (i_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_weight;
    assign w_a = WEIGHT_ONE - w_b;

    // Rounded magnitude terms and the rounded angle sum.
    always_comb begin
        n_ra   = {1'b0, r_mpa} + (MPW+1)'(32768);
        n_rb   = {1'b0, r_mpb} + (MPW+1)'(32768);
        n_asum = {r_apa[APW-1], r_apa} + {r_apb[APW-1], r_apb} + (APW+1)'(32768);
        n_ash  = n_asum >>> 16;
    end

    // Gain rounding and fold of the angle into the right half plane.
    always_comb begin
        n_gr = r_g + GPW'(524288);
        n_mg = MW'(n_gr >> 20);
        if (r_p2 > ANGLE_HALF_PI) begin
            n_x = -$signed(XW'(n_mg));
            n_z = r_p2 - ANGLE_PI;
        end else if (r_p2 < -ANGLE_HALF_PI) begin
            n_x = -$signed(XW'(n_mg));
            n_z = r_p2 + ANGLE_PI;
        end else begin
            n_x = $signed(XW'(n_mg));
            n_z = r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            // Stage one: weighted products.
            r_mpa <= MPW'(i_mag_a) * MPW'(w_a);
            r_mpb <= MPW'(i_mag_b) * MPW'(w_b);
            r_apa <= APW'(i_ang_a) * $signed(APW'({1'b0, w_a}));
            r_apb <= APW'(i_ang_b) * $signed(APW'({1'b0, w_b}));
            // Stage two: blended magnitude and angle.
            r_m   <= MW'(n_ra >> 16) + MW'(n_rb >> 16);
            r_p1  <= n_ash[ZW-1:0];
            // Stage three: gain correction product.
            r_g   <= GPW'(r_m) * GPW'(INV_GAIN_SQ_Q20);
            r_p2  <= r_p1;
            // Stage four: start vector for the rotation chain.
            o_x   <= n_x;
            o_z   <= n_z;
        end
    end
endmodule

@@ rtl/complex_polar_interpolator_top.sv @@
// Top level of the complex polar interpolator: CORDIC vectoring, blend, CORDIC rotation.
//
//  Channel   Dir  Handshake           Payload
//  s_axis    in   tvalid / tready     tdata {second_im, second_re, first_im, first_re}, tlast
//  m_axis    out  tvalid / tready     tdata {blend_im, blend_re}, tlast
//  cfg       in   i_cfg_we (no wait)  i_cfg_wdata = blend_weight
//
//  One request is taken every cycle unless the pipeline stalls; each request passes through
//  the input register, the vectoring cells, the blend stages, the rotation cells and the output register.
//  The whole pipeline advances together; it stalls only when the output register holds
//  a result that the sink does not take.
//  Reset is synchronous and active low; it clears the valid line and the weight.
module complex_polar_interpolator_top #(
    parameter int DATA_WIDTH    = cpi_pkg::DATA_WIDTH_DEF,
    parameter int CORDIC_STAGES = cpi_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [cpi_pkg::WEIGHT_W-1:0]              i_cfg_wdata,
    input  logic                                      s_axis_tvalid,
    output logic                                      s_axis_tready,
    // first_re, first_im, second_re, second_im from bit 0, zero padded to bytes
    input  logic [((4*DATA_WIDTH+7)/8)*8-1:0]         s_axis_tdata,
    input  logic                                      s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  logic                                      m_axis_tready,
    // blend_re, blend_im from bit 0, zero padded to bytes
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]         m_axis_tdata,
    output logic                                      m_axis_tlast
);
    import cpi_pkg::*;

    localparam int W      = DATA_WIDTH;
    localparam int XW     = W + 3;
    localparam int OUT_TW = ((2*W+7)/8)*8;
    localparam int BSTG   = CORDIC_STAGES + 1;
    localparam int RSTG   = CORDIC_STAGES + 5;
    localparam int LAT    = 2*CORDIC_STAGES + 6;

    localparam logic signed [XW-1:0] SAT_HI = {{4{1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{4{1'b1}}, {(W-1){1'b0}}};

    logic [WEIGHT_W-1:0] r_weight;
    logic [LAT-1:0]      r_vld;
    logic [LAT-1:0]      r_last;
    logic                ce;

    logic signed [W-1:0] a_re, a_im, b_re, b_im;

    logic signed [XW-1:0] ax [0:CORDIC_STAGES];
    logic signed [XW-1:0] ay [0:CORDIC_STAGES];
    logic signed [ZW-1:0] az [0:CORDIC_STAGES];
    logic                 azr[0:CORDIC_STAGES];
    logic signed [XW-1:0] bx [0:CORDIC_STAGES];
    logic signed [XW-1:0] by [0:CORDIC_STAGES];
    logic signed [ZW-1:0] bz [0:CORDIC_STAGES];
    logic                 bzr[0:CORDIC_STAGES];
    logic signed [XW-1:0] rx [0:CORDIC_STAGES];
    logic signed [XW-1:0] ry [0:CORDIC_STAGES];
    logic signed [ZW-1:0] rz [0:CORDIC_STAGES];

    logic [W:0]           mag_a, mag_b;
    logic signed [ZW-1:0] ang_a, ang_b;
    logic signed [W-1:0]  r_out_re, r_out_im;
    logic signed [W-1:0]  n_out_re, n_out_im;

    // The line advances unless a finished result waits at the output.
    assign ce            = !r_vld[LAT-1] || m_axis_tready;
    assign s_axis_tready = ce;

    assign a_re = s_axis_tdata[W-1:0];
    assign a_im = s_axis_tdata[2*W-1:W];
    assign b_re = s_axis_tdata[3*W-1:2*W];
    assign b_im = s_axis_tdata[4*W-1:3*W];

    // Configuration register and the valid line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= '0;
            r_vld    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_weight <= i_cfg_wdata;
            end
            if (ce) begin
                r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
            end
        end
    end

    // Last flag and the input stage: left half plane folded by negation.
    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_last <= {r_last[LAT-2:0], s_axis_tlast};
            azr[0] <= (a_re == '0) && (a_im == '0);
            bzr[0] <= (b_re == '0) && (b_im == '0);
            if (a_re[W-1]) begin
                ax[0] <= -XW'(a_re);
                ay[0] <= -XW'(a_im);
                az[0] <= a_im[W-1] ? -ANGLE_PI : ANGLE_PI;
            end else begin
                ax[0] <= XW'(a_re);
                ay[0] <= XW'(a_im);
                az[0] <= '0;
            end
            if (b_re[W-1]) begin
                bx[0] <= -XW'(b_re);
                by[0] <= -XW'(b_im);
                bz[0] <= b_im[W-1] ? -ANGLE_PI : ANGLE_PI;
            end else begin
                bx[0] <= XW'(b_re);
                by[0] <= XW'(b_im);
                bz[0] <= '0;
            end
        end
    end

    // Vectoring chains, one for each input value.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_vec
        cpi_vec_cell #(.XW(XW), .STEP(k)) u_vec_a (
            .i_clk (i_clk), .i_ce (ce),
            .i_x (ax[k]), .i_y (ay[k]), .i_z (az[k]), .i_zero (azr[k]),
            .o_x (ax[k+1]), .o_y (ay[k+1]), .o_z (az[k+1]), .o_zero (azr[k+1])
        );
        cpi_vec_cell #(.XW(XW), .STEP(k)) u_vec_b (
            .i_clk (i_clk), .i_ce (ce),
            .i_x (bx[k]), .i_y (by[k]), .i_z (bz[k]), .i_zero (bzr[k]),
            .o_x (bx[k+1]), .o_y (by[k+1]), .o_z (bz[k+1]), .o_zero (bzr[k+1])
        );
    end

    // Zero vector reads as magnitude zero, angle zero.
    always_comb begin
        mag_a = (azr[CORDIC_STAGES] || ax[CORDIC_STAGES][XW-1]) ? '0
                : ax[CORDIC_STAGES][W:0];
        mag_b = (bzr[CORDIC_STAGES] || bx[CORDIC_STAGES][XW-1]) ? '0
                : bx[CORDIC_STAGES][W:0];
        ang_a = azr[CORDIC_STAGES] ? '0 : az[CORDIC_STAGES];
        ang_b = bzr[CORDIC_STAGES] ? '0 : bz[CORDIC_STAGES];
    end

    cpi_blend #(.DATA_WIDTH(W)) u_blend (
        .i_clk    (i_clk),
        .i_ce     (ce),
        .i_weight (r_weight),
        .i_mag_a  (mag_a),
        .i_mag_b  (mag_b),
        .i_ang_a  (ang_a),
        .i_ang_b  (ang_b),
        .o_x      (rx[0]),
        .o_z      (rz[0])
    );
    assign ry[0] = '0;

    // Rotation chain back to rectangular form.
    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_rot
        cpi_rot_cell #(.XW(XW), .STEP(k)) u_rot (
            .i_clk (i_clk), .i_ce (ce),
            .i_x (rx[k]), .i_y (ry[k]), .i_z (rz[k]),
            .o_x (rx[k+1]), .o_y (ry[k+1]), .o_z (rz[k+1])
        );
    end

    // Saturate into the output register.
    always_comb begin
        if (rx[CORDIC_STAGES] > SAT_HI) begin
            n_out_re = SAT_HI[W-1:0];
        end else if (rx[CORDIC_STAGES] < SAT_LO) begin
            n_out_re = SAT_LO[W-1:0];
        end else begin
            n_out_re = rx[CORDIC_STAGES][W-1:0];
        end
        if (ry[CORDIC_STAGES] > SAT_HI) begin
            n_out_im = SAT_HI[W-1:0];
        end else if (ry[CORDIC_STAGES] < SAT_LO) begin
            n_out_im = SAT_LO[W-1:0];
        end else begin
            n_out_im = ry[CORDIC_STAGES][W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_out_re <= n_out_re;
            r_out_im <= n_out_im;
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tlast  = r_last[LAT-1];
    assign m_axis_tdata  = OUT_TW'({r_out_im, r_out_re});

`ifndef ASSERT_OFF
    // An accepted request always enters the first stage.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[0])
        else $error("accepted request lost at input stage");

    // A stalled pipeline holds every valid bit.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !ce |=> $stable(r_vld))
        else $error("valid line moved during stall");

    // Requests in flight grow by at most one per cycle.
    a_inflight_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ##1 $countones(r_vld) <= $past($countones(r_vld)) + 1)
        else $error("more than one request entered in a cycle");

    // The blend stage and the rotation start move only with the line.
    a_blend_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ce && r_vld[BSTG-1] |=> r_vld[BSTG] && (r_vld[RSTG-1] == $past(r_vld[RSTG-2])))
        else $error("blend stage out of step");
`endif
endmodule
